@@ rtl/core/skt_pkg.sv @@
package skt_pkg;

    // fixed widths of the command and response fields
    localparam int DAY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                load;
        logic                idx_from_count;
        logic                idx_from_pos;
        logic                rd_prev;
        logic                rd_next;
        logic                wr_shift;
        logic                wr_new;
        logic                idx_dec;
        logic                idx_inc;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                mark_at;
        logic                publish;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic bad_pos;
        logic idx_zero;
        logic idx_last;
        logic key_ge;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/skt_ctrl.sv @@
module skt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  skt_pkg::t_dp_stat i_stat,
    output skt_pkg::t_dp_cmd  o_cmd
);
    import skt_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_INS_CHECK = 4'd2;
    localparam logic [3:0] S_INS_CMP   = 4'd3;
    localparam logic [3:0] S_INS_PLACE = 4'd4;
    localparam logic [3:0] S_RM_CHECK  = 4'd5;
    localparam logic [3:0] S_RM_MOVE   = 4'd6;
    localparam logic [3:0] S_RESULT    = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.kind == KIND_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                        n_state      = S_RESULT;
                    end else begin
                        o_cmd.status         = ST_DONE;
                        o_cmd.idx_from_count = 1'b1;
                        n_state              = S_INS_CHECK;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                        n_state      = S_RESULT;
                    end else if (i_stat.bad_pos) begin
                        o_cmd.status = ST_NOT_FOUND;
                        n_state      = S_RESULT;
                    end else begin
                        o_cmd.status       = ST_DONE;
                        o_cmd.idx_from_pos = 1'b1;
                        n_state            = S_RM_CHECK;
                    end
                end
            end
            // walk back from the tail, moving each larger-or-equal entry up
            S_INS_CHECK: begin
                if (i_stat.idx_zero) begin
                    n_state = S_INS_PLACE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.key_ge) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.idx_dec  = 1'b1;
                    n_state        = S_INS_CHECK;
                end else begin
                    n_state = S_INS_PLACE;
                end
            end
            S_INS_PLACE: begin
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.mark_at = 1'b1;
                n_state       = S_RESULT;
            end
            // close the gap by pulling later entries down
            S_RM_CHECK: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_RM_MOVE;
                end
            end
            S_RM_MOVE: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_RM_CHECK;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_stat.out_free)
        else $error("response word published over a pending one");

    a_no_grow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> !i_stat.full)
        else $error("insert completed into a full table");

    a_load_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DECIDE))
        else $error("accepted word not followed by decision");

endmodule

@@ rtl/core/skt_datapath.sv @@
module skt_datapath #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  skt_pkg::t_dp_cmd                i_cmd,
    output skt_pkg::t_dp_stat               o_stat,
    input  logic                            i_kind,
    input  logic [skt_pkg::DAY_W-1:0]       i_entry_day,
    input  logic [skt_pkg::HANDLE_W-1:0]    i_task_handle,
    input  logic [skt_pkg::POS_W-1:0]       i_position,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output logic [skt_pkg::STATUS_W-1:0]    o_status,
    output logic [skt_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [skt_pkg::COUNT_W-1:0]     o_inserted_at
);
    import skt_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = KEY_BITS + HANDLE_BITS;
    localparam int CMP_W  = CNT_W + POS_W;

    logic [WORD_W-1:0]      mem [DEPTH];
    logic [WORD_W-1:0]      r_rd_data;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_kind;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [POS_W-1:0]       r_pos;
    logic [STATUS_W-1:0]    r_status;
    logic [COUNT_W-1:0]     r_at;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [COUNT_W-1:0]     r_out_count;
    logic [COUNT_W-1:0]     r_out_at;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W:0]         idx_plus;

    assign idx_plus = {1'b0, r_idx} + (IDX_W + 1)'(1);
    assign rd_addr  = i_cmd.rd_prev ? (r_idx - IDX_W'(1)) : (r_idx + IDX_W'(1));

    // storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            mem[r_idx] <= {r_key, r_handle};
        end else if (i_cmd.wr_shift) begin
            mem[r_idx] <= r_rd_data;
        end
        if (i_cmd.rd_prev || i_cmd.rd_next) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // command word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= KEY_BITS'(i_entry_day);
            r_handle <= HANDLE_BITS'(i_task_handle);
            r_pos    <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_from_count) begin
            r_idx <= IDX_W'(r_count);
        end else if (i_cmd.idx_from_pos) begin
            r_idx <= IDX_W'(r_pos - POS_W'(1));
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - IDX_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load) begin
            r_at <= '0;
        end else if (i_cmd.mark_at) begin
            r_at <= COUNT_W'(idx_plus);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // response register, frees the walk from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            r_out_at     <= r_at;
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_inserted_at = r_out_at;

    always_comb begin
        o_stat          = '0;
        o_stat.kind     = r_kind;
        o_stat.full     = (r_count == CNT_W'(DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.bad_pos  = (r_pos == '0) || (CMP_W'(r_pos) > CMP_W'(r_count));
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (CNT_W'(idx_plus) == r_count);
        o_stat.key_ge   = (r_rd_data[WORD_W-1:HANDLE_BITS] >= r_key);
        o_stat.out_free = !r_out_valid || i_rsp_ready;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> r_out_valid)
        else $error("published response not presented");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_shift && r_kind == KIND_INSERT) |-> o_stat.key_ge)
        else $error("insert shifted a smaller key");

endmodule

@@ rtl/core/sorted_key_table_top.sv @@
// channel | direction | handshake                 | payload
// cmd     | in        | i_cmd_valid / o_cmd_ready | i_kind i_entry_day i_task_handle i_position
// rsp     | out       | o_rsp_valid / i_rsp_ready | o_status o_entry_count o_inserted_at
//
// from acceptance to the next ready, a remove walks the moved entries and an insert does the
// same, then places the new entry, with one more read and compare when the walk stops on a
// smaller day; the walk over the entry memory takes one read and one write per moved entry
// a rejected command (full, empty, bad position) goes from the decision straight to the result step
// reset clears the entry count, the response valid flag and the control state only; no clearing pass
// a waiting response word stalls only the next command's final step
module sorted_key_table_top #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  logic                            i_kind,
    input  logic [skt_pkg::DAY_W-1:0]       i_entry_day,
    input  logic [skt_pkg::HANDLE_W-1:0]    i_task_handle,
    input  logic [skt_pkg::POS_W-1:0]       i_position,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output logic [skt_pkg::STATUS_W-1:0]    o_status,
    output logic [skt_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [skt_pkg::COUNT_W-1:0]     o_inserted_at
);
    import skt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    skt_datapath #(
        .DEPTH       (DEPTH),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_kind        (i_kind),
        .i_entry_day   (i_entry_day),
        .i_task_handle (i_task_handle),
        .i_position    (i_position),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_inserted_at (o_inserted_at)
    );

endmodule
